>>> rtl/prbt_pkg.sv
// Shared constants, codes and control/status types of the pre-alarm ring buffer tracker.
package prbt_pkg;

  localparam int NumChannels    = 4;
  localparam int KeyEntries     = 32;
  localparam int MaxBufferBytes = 16777216;

  localparam int ChW    = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int KiW    = $clog2(KeyEntries);
  localparam int PosW   = $clog2(MaxBufferBytes) + 1;
  localparam int TimeW  = 32;
  localparam int WinW   = 16;
  localparam int CntW   = 21;
  localparam int OffW   = 24;
  localparam int LenW   = 25;
  localparam int MemAw  = ChW + KiW;
  localparam int MemDep = 2 ** MemAw;

  localparam logic [1:0] OpSave  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpGet   = 2'd2;

  typedef struct packed {
    logic load;
    logic save_commit;
    logic save2_commit;
    logic get_commit;
    logic rd_cur;
    logic cur_capture;
    logic live_commit;
    logic walk_first;
    logic walk_step;
    logic res_issue;
    logic res_commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       in_ch_ok;
    logic       win_zero;
    logic       walk_done;
    logic       save_wrap;
    logic       out_ready;
  } sts_t;

  function automatic logic [KiW-1:0] ki_prev(input logic [KiW-1:0] i);
    return (i == '0) ? KiW'(KeyEntries - 1) : i - 1'b1;
  endfunction

  function automatic logic [KiW-1:0] ki_next(input logic [KiW-1:0] i);
    return (i == KiW'(KeyEntries - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

>>> rtl/prbt_ctrl.sv
// Sequencing state machine of the pre-alarm ring buffer tracker.
module prbt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  prbt_pkg::sts_t sts_i,
  output prbt_pkg::cmd_t cmd_o,
  output logic           busy_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SSave  = 3'd1;
  localparam logic [2:0] SSave2 = 3'd2;
  localparam logic [2:0] SGet   = 3'd3;
  localparam logic [2:0] SStRd  = 3'd4;
  localparam logic [2:0] SStCur = 3'd5;
  localparam logic [2:0] SWalk  = 3'd6;
  localparam logic [2:0] SRes   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_ch_ok) begin
            priority if (sts_i.in_op == prbt_pkg::OpSave) begin
              state_d = SSave;
            end else if (sts_i.in_op == prbt_pkg::OpStart) begin
              state_d = SStRd;
            end else if (sts_i.in_op == prbt_pkg::OpGet) begin
              state_d = SGet;
            end else begin
              // drop unused opcodes
              state_d = SIdle;
            end
          end
        end
      end
      SSave: begin
        if (sts_i.out_ready) begin
          cmd_o.save_commit = 1'b1;
          state_d = sts_i.save_wrap ? SSave2 : SIdle;
        end
      end
      SSave2: begin
        if (sts_i.out_ready) begin
          cmd_o.save2_commit = 1'b1;
          state_d = SIdle;
        end
      end
      SGet: begin
        if (sts_i.out_ready) begin
          cmd_o.get_commit = 1'b1;
          state_d = SIdle;
        end
      end
      SStRd: begin
        cmd_o.rd_cur = 1'b1;
        state_d = SStCur;
      end
      SStCur: begin
        cmd_o.cur_capture = 1'b1;
        if (sts_i.win_zero) begin
          if (sts_i.out_ready) begin
            cmd_o.live_commit = 1'b1;
            state_d = SIdle;
          end
        end else begin
          cmd_o.walk_first = 1'b1;
          state_d = SWalk;
        end
      end
      SWalk: begin
        if (sts_i.walk_done) begin
          cmd_o.res_issue = 1'b1;
          state_d = SRes;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      SRes: begin
        if (sts_i.out_ready) begin
          cmd_o.res_commit = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);

endmodule

>>> rtl/prbt_dp.sv
// Datapath: channel state, key-frame ring memory, arithmetic and result register.
module prbt_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prbt_pkg::cmd_t              cmd_i,
  output prbt_pkg::sts_t              sts_o,
  input  logic                        cfg_we_i,
  input  logic [prbt_pkg::LenW-1:0]   buffer_bytes_i,
  input  logic [1:0]                  opcode_i,
  input  logic [1:0]                  channel_i,
  input  logic [prbt_pkg::CntW-1:0]   byte_count_i,
  input  logic                        is_key_frame_i,
  input  logic [prbt_pkg::TimeW-1:0]  now_seconds_i,
  input  logic [prbt_pkg::WinW-1:0]   window_seconds_i,
  input  logic                        whole_before_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  op_echo_o,
  output logic [prbt_pkg::OffW-1:0]   offset_o,
  output logic [prbt_pkg::LenW-1:0]   length_o,
  output logic                        window_done_o,
  output logic                        last_o
);

  localparam int PosW  = prbt_pkg::PosW;
  localparam int TimeW = prbt_pkg::TimeW;
  localparam int WinW  = prbt_pkg::WinW;
  localparam int ChW   = prbt_pkg::ChW;
  localparam int KiW   = prbt_pkg::KiW;
  localparam int NCh   = prbt_pkg::NumChannels;

  // Item
  logic [ChW-1:0]   ch_q;
  logic [PosW-1:0]  cnt_q;
  logic             key_q;
  logic [TimeW-1:0] now_q;
  logic [WinW-1:0]  win_q;
  logic             whole_q;

  logic [PosW-1:0]  size_q;

  // Per-channel state
  logic [PosW-1:0]  wpos_q   [NCh];
  logic [PosW-1:0]  rpos_q   [NCh];
  logic [PosW-1:0]  epos_q   [NCh];
  logic [WinW-1:0]  wlen_q   [NCh];
  logic             eknown_q [NCh];
  logic [TimeW-1:0] wstart_q [NCh];
  logic [KiW-1:0]   kcur_q   [NCh];

  // Working registers
  logic [PosW-1:0]  wp_q, rp_q, len_q, seg2_q, cur_pos_q;
  logic [TimeW-1:0] cur_time_q;
  logic [KiW-1:0]   chk_idx_q, chk_n_q;

  // Key ring memory
  logic [PosW+TimeW-1:0]     mem_q [prbt_pkg::MemDep];
  logic [prbt_pkg::MemDep-1:0] vld_q;
  logic [PosW+TimeW-1:0]     rd_q;
  logic                      rd_vld_q;
  logic                      rd_en;
  logic [prbt_pkg::MemAw-1:0] rd_addr;

  // Result register
  logic                      out_vld_q;
  logic [1:0]                out_op_q;
  logic [prbt_pkg::OffW-1:0] out_off_q;
  logic [prbt_pkg::LenW-1:0] out_len_q;
  logic                      out_done_q, out_last_q;

  logic [ChW-1:0]   ch_in;
  logic [PosW-1:0]  cnt_in, size_in;
  logic             out_ready;
  logic [TimeW-1:0] rd_time;
  logic [PosW-1:0]  rd_pos;
  logic [WinW-1:0]  span;
  logic [TimeW:0]   wdiff, sdiff;
  logic             walk_hit;
  logic [KiW-1:0]   res_idx, knext;

  // Save
  logic [PosW-1:0]  leave;
  logic             win_close;

  // Get
  logic [PosW-1:0]  g_wp, g_ep, g_len, g_n, g_rp_next;
  logic             g_done;

  assign ch_in  = channel_i[ChW-1:0];
  assign cnt_in = PosW'(byte_count_i);

  always_comb begin
    if (buffer_bytes_i == '0) begin
      size_in = PosW'(1);
    end else if (buffer_bytes_i > PosW'(prbt_pkg::MaxBufferBytes)) begin
      size_in = PosW'(prbt_pkg::MaxBufferBytes);
    end else begin
      size_in = buffer_bytes_i;
    end
  end

  assign out_ready = !out_vld_q || !out_stall_i;
  assign rd_time   = rd_vld_q ? rd_q[TimeW-1:0] : '0;
  assign rd_pos    = rd_vld_q ? rd_q[PosW+TimeW-1:TimeW] : '0;
  assign span      = whole_q ? win_q : (win_q >> 1);

  // Signed age of the entry under test relative to the current key frame
  assign sdiff    = {1'b0, cur_time_q} - {1'b0, rd_time};
  assign walk_hit = (rd_time == '0) || (!sdiff[TimeW] && sdiff[TimeW-1:0] >= TimeW'(span))
                    || (chk_n_q == KiW'(prbt_pkg::KeyEntries - 1));
  assign res_idx  = (rd_time == '0) ? prbt_pkg::ki_next(chk_idx_q) : chk_idx_q;

  assign leave     = size_q - wp_q;
  assign knext     = prbt_pkg::ki_next(kcur_q[ch_q]);
  assign wdiff     = {1'b0, now_q} - {1'b0, wstart_q[ch_q]};
  assign win_close = (wlen_q[ch_q] != '0) && !eknown_q[ch_q] && !wdiff[TimeW]
                     && (wdiff[TimeW-1:0] >= TimeW'(wlen_q[ch_q]));

  always_comb begin
    g_wp      = wpos_q[ch_q];
    g_ep      = epos_q[ch_q];
    g_len     = '0;
    g_n       = '0;
    g_rp_next = rp_q;
    g_done    = 1'b0;
    priority if (!eknown_q[ch_q]) begin
      if (g_wp != rp_q) begin
        g_len     = (g_wp > rp_q) ? g_wp - rp_q : size_q - rp_q;
        g_n       = (g_len > cnt_q) ? cnt_q : g_len;
        g_rp_next = rp_q + g_n;
      end
    end else if (rp_q > g_ep) begin
      g_len = size_q - rp_q;
      if (g_len > cnt_q) begin
        g_n       = cnt_q;
        g_rp_next = rp_q + cnt_q;
      end else begin
        g_n       = g_len;
        g_rp_next = '0;
      end
    end else if (rp_q < g_ep) begin
      g_len = g_ep - rp_q;
      if (g_len > cnt_q) begin
        g_n       = cnt_q;
        g_rp_next = rp_q + cnt_q;
      end else begin
        g_n    = g_len;
        g_done = 1'b1;
      end
    end else begin
      g_done = 1'b1;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {ch_q, kcur_q[ch_q]};
    priority if (cmd_i.rd_cur) begin
      rd_en = 1'b1;
    end else if (cmd_i.walk_first) begin
      rd_en   = 1'b1;
      rd_addr = {ch_q, prbt_pkg::ki_prev(kcur_q[ch_q])};
    end else if (cmd_i.walk_step) begin
      rd_en   = 1'b1;
      rd_addr = {ch_q, prbt_pkg::ki_prev(chk_idx_q)};
    end else if (cmd_i.res_issue) begin
      rd_en   = 1'b1;
      rd_addr = {ch_q, res_idx};
    end else begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.in_op     = opcode_i;
    sts_o.in_ch_ok  = (int'(channel_i) < NCh);
    sts_o.win_zero  = (win_q == '0);
    sts_o.walk_done = walk_hit;
    sts_o.save_wrap = (leave < len_q);
    sts_o.out_ready = out_ready;
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.save_commit && key_q) begin
      mem_q[{ch_q, knext}] <= {wp_q, now_q};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q    <= ch_in;
      cnt_q   <= cnt_in;
      key_q   <= is_key_frame_i;
      now_q   <= now_seconds_i;
      win_q   <= window_seconds_i;
      whole_q <= whole_before_i;
      wp_q    <= (wpos_q[ch_in] >= size_q) ? '0 : wpos_q[ch_in];
      rp_q    <= (rpos_q[ch_in] >= size_q) ? '0 : rpos_q[ch_in];
      len_q   <= (cnt_in > size_q) ? size_q : cnt_in;
    end
    if (cmd_i.save_commit) begin
      seg2_q <= len_q - leave;
    end
    if (cmd_i.cur_capture) begin
      cur_time_q <= rd_time;
      cur_pos_q  <= rd_pos;
    end
    if (cmd_i.walk_first) begin
      chk_idx_q <= prbt_pkg::ki_prev(kcur_q[ch_q]);
      chk_n_q   <= KiW'(1);
    end else if (cmd_i.walk_step) begin
      chk_idx_q <= prbt_pkg::ki_prev(chk_idx_q);
      chk_n_q   <= chk_n_q + 1'b1;
    end
    if (cmd_i.save_commit) begin
      out_op_q   <= prbt_pkg::OpSave;
      out_off_q  <= wp_q[prbt_pkg::OffW-1:0];
      out_len_q  <= (leave < len_q) ? leave : len_q;
      out_done_q <= 1'b0;
      out_last_q <= !(leave < len_q);
    end else if (cmd_i.save2_commit) begin
      out_op_q   <= prbt_pkg::OpSave;
      out_off_q  <= '0;
      out_len_q  <= seg2_q;
      out_done_q <= 1'b0;
      out_last_q <= 1'b1;
    end else if (cmd_i.live_commit || cmd_i.res_commit) begin
      out_op_q   <= prbt_pkg::OpStart;
      out_off_q  <= rd_pos[prbt_pkg::OffW-1:0];
      out_len_q  <= '0;
      out_done_q <= 1'b0;
      out_last_q <= 1'b1;
    end else if (cmd_i.get_commit) begin
      out_op_q   <= prbt_pkg::OpGet;
      out_off_q  <= rp_q[prbt_pkg::OffW-1:0];
      out_len_q  <= g_n;
      out_done_q <= g_done;
      out_last_q <= 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= PosW'(prbt_pkg::MaxBufferBytes);
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NCh; i++) begin
        wpos_q[i]   <= '0;
        rpos_q[i]   <= '0;
        epos_q[i]   <= '0;
        wlen_q[i]   <= '0;
        eknown_q[i] <= 1'b0;
        wstart_q[i] <= '0;
        kcur_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        size_q <= size_in;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (cmd_i.save_commit || cmd_i.save2_commit || cmd_i.live_commit
          || cmd_i.res_commit || cmd_i.get_commit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      if (cmd_i.save_commit) begin
        if (key_q) begin
          kcur_q[ch_q]           <= knext;
          vld_q[{ch_q, knext}]   <= 1'b1;
          if (win_close) begin
            epos_q[ch_q]   <= wp_q;
            eknown_q[ch_q] <= 1'b1;
          end
        end
        priority if (leave > len_q) begin
          wpos_q[ch_q] <= wp_q + len_q;
        end else if (leave == len_q) begin
          wpos_q[ch_q] <= '0;
        end else begin
          wpos_q[ch_q] <= len_q - leave;
        end
      end

      if (cmd_i.live_commit) begin
        rpos_q[ch_q]   <= rd_pos;
        wlen_q[ch_q]   <= '0;
        eknown_q[ch_q] <= 1'b0;
      end

      if (cmd_i.res_commit) begin
        wlen_q[ch_q] <= win_q;
        rpos_q[ch_q] <= rd_pos;
        if (whole_q) begin
          eknown_q[ch_q] <= 1'b1;
          epos_q[ch_q]   <= cur_pos_q;
        end else begin
          eknown_q[ch_q] <= 1'b0;
          wstart_q[ch_q] <= rd_time;
          epos_q[ch_q]   <= '0;
        end
      end

      if (cmd_i.get_commit) begin
        rpos_q[ch_q] <= g_rp_next;
        if (g_done) begin
          wlen_q[ch_q] <= '0;
        end
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign op_echo_o     = out_op_q;
  assign offset_o      = out_off_q;
  assign length_o      = out_len_q;
  assign window_done_o = out_done_q;
  assign last_o        = out_last_q;

endmodule

>>> rtl/prealarm_ring_buffer_tracker.sv
// Top level of the pre-alarm ring buffer tracker: controller plus datapath.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------------
//  in      | in_valid_i / in_stall_o    | opcode, channel, byte_count, is_key_frame,
//          |                            | now_seconds, window_seconds, whole_before
//  out     | out_valid_o / out_stall_i  | op_echo, offset, length, window_done, last
//  cfg     | cfg_valid_i / cfg_ready_o  | buffer_bytes
//
// One item at a time. Save goes through SSave (and SSave2 when the frame wraps), get through SGet,
// start through SStRd and SStCur when live and otherwise on through SWalk and SRes, walking at most
// KeyEntries-1 key entries: the walk reads one ring entry a cycle through the key memory port.
// A full result register parts the sides; out_stall_i holds the commit cycle.
// Reset clears all channel state and the key ring valid bits at once; no clearing pass.
module prealarm_ring_buffer_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [prbt_pkg::LenW-1:0]   buffer_bytes_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [1:0]                  channel_i,
  input  logic [prbt_pkg::CntW-1:0]   byte_count_i,
  input  logic                        is_key_frame_i,
  input  logic [prbt_pkg::TimeW-1:0]  now_seconds_i,
  input  logic [prbt_pkg::WinW-1:0]   window_seconds_i,
  input  logic                        whole_before_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  op_echo_o,
  output logic [prbt_pkg::OffW-1:0]   offset_o,
  output logic [prbt_pkg::LenW-1:0]   length_o,
  output logic                        window_done_o,
  output logic                        last_o
);

  prbt_pkg::cmd_t cmd;
  prbt_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  prbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (in_stall_o)
  );

  prbt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .buffer_bytes_i   (buffer_bytes_i),
    .opcode_i         (opcode_i),
    .channel_i        (channel_i),
    .byte_count_i     (byte_count_i),
    .is_key_frame_i   (is_key_frame_i),
    .now_seconds_i    (now_seconds_i),
    .window_seconds_i (window_seconds_i),
    .whole_before_i   (whole_before_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .op_echo_o        (op_echo_o),
    .offset_o         (offset_o),
    .length_o         (length_o),
    .window_done_o    (window_done_o),
    .last_o           (last_o)
  );

endmodule
